>>> hw/rtl/lctbc_pkg.sv
// Package for the line comment to block comment converter.
// Holds the lexer state type, the character codes and the command queue types.
// No dependencies.
package lctbc_pkg;

  typedef enum logic [2:0] {
    LEX_NORMAL    = 3'd0,
    LEX_STRING    = 3'd1,
    LEX_STR_ESC   = 3'd2,
    LEX_SLASH     = 3'd3,
    LEX_LINE_CMT  = 3'd4,
    LEX_BLOCK_CMT = 3'd5,
    LEX_STAR      = 3'd6
  } lex_state_t;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Command queue between the lexer and the expander.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified byte: the byte to emit and whether it closes a line comment.
  typedef struct packed {
    logic [7:0] data;
    logic       close;
  } cmd_t;

  // Expansion step of a closing command.
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

endpackage

>>> hw/rtl/lctbc_front.sv
// Lexer front end: tracks strings and comments and classifies each byte.
// Depends on lctbc_pkg.
module lctbc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        text_byte,
  input  logic              q_full,
  output logic              q_wr,
  output lctbc_pkg::cmd_t   q_wr_data
);

  lctbc_pkg::lex_state_t state;
  lctbc_pkg::lex_state_t state_next;
  logic                  take;

  assign take = push && !q_full;
  assign q_wr = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lctbc_pkg::LEX_NORMAL;
    end else if (take) begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lctbc_pkg::LEX_STRING: begin
        if (text_byte == lctbc_pkg::CH_QUOTE) state_next = lctbc_pkg::LEX_NORMAL;
        else if (text_byte == lctbc_pkg::CH_BSLASH) state_next = lctbc_pkg::LEX_STR_ESC;
      end
      lctbc_pkg::LEX_STR_ESC: begin
        state_next = lctbc_pkg::LEX_STRING;
      end
      lctbc_pkg::LEX_SLASH: begin
        if (text_byte == lctbc_pkg::CH_SLASH) state_next = lctbc_pkg::LEX_LINE_CMT;
        else if (text_byte == lctbc_pkg::CH_STAR) state_next = lctbc_pkg::LEX_BLOCK_CMT;
        else if (text_byte == lctbc_pkg::CH_QUOTE) state_next = lctbc_pkg::LEX_STRING;
        else state_next = lctbc_pkg::LEX_NORMAL;
      end
      lctbc_pkg::LEX_LINE_CMT: begin
        if (text_byte == lctbc_pkg::CH_LF || text_byte == lctbc_pkg::CH_CR) begin
          state_next = lctbc_pkg::LEX_NORMAL;
        end
      end
      lctbc_pkg::LEX_BLOCK_CMT: begin
        if (text_byte == lctbc_pkg::CH_STAR) state_next = lctbc_pkg::LEX_STAR;
      end
      lctbc_pkg::LEX_STAR: begin
        if (text_byte == lctbc_pkg::CH_SLASH) state_next = lctbc_pkg::LEX_NORMAL;
        else if (text_byte == lctbc_pkg::CH_STAR) state_next = lctbc_pkg::LEX_STAR;
        else state_next = lctbc_pkg::LEX_BLOCK_CMT;
      end
      default: begin
        if (text_byte == lctbc_pkg::CH_SLASH) state_next = lctbc_pkg::LEX_SLASH;
        else if (text_byte == lctbc_pkg::CH_QUOTE) state_next = lctbc_pkg::LEX_STRING;
        else state_next = lctbc_pkg::LEX_NORMAL;
      end
    endcase
  end

  // Outputs: the second slash becomes a star, a line end closes a line comment.
  always_comb begin
    q_wr_data.data  = text_byte;
    q_wr_data.close = 1'b0;
    unique case (state)
      lctbc_pkg::LEX_SLASH: begin
        if (text_byte == lctbc_pkg::CH_SLASH) q_wr_data.data = lctbc_pkg::CH_STAR;
      end
      lctbc_pkg::LEX_LINE_CMT: begin
        q_wr_data.close = (text_byte == lctbc_pkg::CH_LF) ||
                          (text_byte == lctbc_pkg::CH_CR);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/lctbc_queue.sv
// Short command queue between the lexer and the expander.
// Depends on lctbc_pkg.
module lctbc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  lctbc_pkg::cmd_t wr_data,
  output logic            q_full,
  input  logic            rd,
  output logic            q_empty,
  output lctbc_pkg::cmd_t rd_data
);

  lctbc_pkg::cmd_t                   slots [lctbc_pkg::QUEUE_DEPTH];
  logic [lctbc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [lctbc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [lctbc_pkg::QCNT_W-1:0]      count;
  logic                              do_wr;
  logic                              do_rd;

  assign q_full  = (count == lctbc_pkg::QCNT_W'(lctbc_pkg::QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

>>> hw/rtl/lctbc_back.sv
// Expander back end: turns queued commands into output beats and holds the output register.
// Depends on lctbc_pkg.
module lctbc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  lctbc_pkg::cmd_t rd_data,
  output logic            rd,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);

  logic                  out_valid;
  lctbc_pkg::phase_t     phase;
  logic                  load;
  logic [7:0]            beat_byte;
  logic                  beat_last;

  assign empty = !out_valid;
  assign load  = (!out_valid || pop) && !q_empty;

  // A closing command spends three beats: star, slash, then the line end.
  always_comb begin
    beat_byte = rd_data.data;
    beat_last = 1'b1;
    if (rd_data.close) begin
      unique case (phase)
        lctbc_pkg::PH_FIRST: begin
          beat_byte = lctbc_pkg::CH_STAR;
          beat_last = 1'b0;
        end
        lctbc_pkg::PH_SECOND: begin
          beat_byte = lctbc_pkg::CH_SLASH;
          beat_last = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign rd = load && beat_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= lctbc_pkg::PH_FIRST;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (beat_last) phase <= lctbc_pkg::PH_FIRST;
        else if (phase == lctbc_pkg::PH_FIRST) phase <= lctbc_pkg::PH_SECOND;
        else phase <= lctbc_pkg::PH_THIRD;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= beat_byte;
      last_of_run <= beat_last;
    end
  end

endmodule

>>> hw/rtl/line_comment_to_block_comment.sv
// Line comment to block comment converter, top level.
// Joins the lexer front end, the command queue and the expander back end.
// Depends on lctbc_pkg, lctbc_front, lctbc_queue and lctbc_back.
//
// Use: source text enters one byte per beat on text_byte, taken when push is
// high and full is low. Each double-slash comment is rewritten as a
// slash-star comment: the second slash comes out as a star, and the CR or
// LF that ends the comment comes out as star, slash, then the line end.
// Strings and block comments pass unchanged. Results leave on out_byte and
// last_of_run; the oldest result is shown while empty is low and is taken
// when pop is high. last_of_run marks the final beat produced by one input.
// An accepted byte is written into the command queue, and its first result
// is then loaded into the output register, ready to pop there.
// Throughput is one input byte per cycle while full is low; only a byte that
// closes a line comment expands to three beats. A four-entry command queue
// between the lexer and the expander absorbs that expansion, so full rises
// only when it is used up or the receiver stalls. While pop stays low, the
// output register holds its beat and the queue fills, then full goes high.
// Synchronous reset empties the queue and the output and puts the lexer in
// its normal code state. Nothing is flushed at the end of the text.
module line_comment_to_block_comment (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  lctbc_pkg::cmd_t wr_data;
  lctbc_pkg::cmd_t rd_data;
  logic            wr;
  logic            rd;
  logic            q_full;
  logic            q_empty;

  assign full = q_full;

  lctbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .text_byte (text_byte),
    .q_full    (q_full),
    .q_wr      (wr),
    .q_wr_data (wr_data)
  );

  lctbc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .wr_data (wr_data),
    .q_full  (q_full),
    .rd      (rd),
    .q_empty (q_empty),
    .rd_data (rd_data)
  );

  lctbc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .rd_data     (rd_data),
    .rd          (rd),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
